### rtl/vp8l_single_pixel_decoder_assert.svh
// Assertion macros used by the top-level decoder RTL.
`ifndef VP8L_SINGLE_PIXEL_DECODER_ASSERT_SVH
`define VP8L_SINGLE_PIXEL_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// a holds in a cycle -> c holds in the same cycle
`define VP8L_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("vp8l check failed");
// a holds in a cycle -> c holds in the next one
`define VP8L_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("vp8l check failed");
`else
`define VP8L_ASSERT_NOW(label, clk, rst_n, a, c)
`define VP8L_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### rtl/vp8l_pkg.sv
package vp8l_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_out_word;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_MALFORMED   = 2'd1;
    localparam logic [1:0] ST_BUDGET      = 2'd2;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

    localparam logic [1:0] FAIL_NONE        = 2'd0;
    localparam logic [1:0] FAIL_MALFORMED   = 2'd1;
    localparam logic [1:0] FAIL_UNSUPPORTED = 2'd3;

    localparam logic [0:0] CFG_MAX_DIM    = 1'd0;
    localparam logic [0:0] CFG_MAX_PIXELS = 1'd1;

    localparam logic [14:0] MAX_DIM_RESET    = 15'd16384;
    localparam logic [28:0] MAX_PIXELS_RESET = 29'd268435456;

    localparam logic [5:0] PS_SIG  = 6'd0;
    localparam logic [5:0] PS_W    = 6'd1;
    localparam logic [5:0] PS_H    = 6'd2;
    localparam logic [5:0] PS_A    = 6'd3;
    localparam logic [5:0] PS_V    = 6'd4;
    localparam logic [5:0] PS_TP   = 6'd5;
    localparam logic [5:0] PS_CC   = 6'd6;
    localparam logic [5:0] PS_META = 6'd7;
    localparam logic [5:0] PS_TT   = 6'd8;
    localparam logic [5:0] PS_TS   = 6'd9;
    localparam logic [5:0] PS_MORE = 6'd10;
    localparam logic [5:0] PS_SYM  = 6'd11;
    localparam logic [5:0] PS_DONE = 6'd31;

    localparam logic [1:0] IMG_DIRECT  = 2'd0;
    localparam logic [1:0] IMG_PALETTE = 2'd1;
    localparam logic [1:0] IMG_INDEX   = 2'd2;

    localparam logic [7:0] VP8L_SIGNATURE = 8'h2f;

    // bit-level parser state
    typedef struct packed {
        logic [5:0]  step;
        logic [13:0] accum;
        logic [3:0]  bidx;
        logic [13:0] wlo;
        logic [13:0] hlo;
        logic [2:0]  flags;
        logic [1:0]  fail;
        logic [31:0] pixel;
    } t_pstate;

    // end-of-file summary handed to the status stage
    typedef struct packed {
        logic        early_bad;
        logic        tp_bad;
        logic        late_bad;
        logic [13:0] wlo;
        logic [13:0] hlo;
        logic [31:0] pixel;
    } t_snap;

    // expected container bytes at offsets 0..3 and 8..15
    function automatic logic [7:0] tag_byte(logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h52;
            4'd1:    r = 8'h49;
            4'd2:    r = 8'h46;
            4'd3:    r = 8'h46;
            4'd8:    r = 8'h57;
            4'd9:    r = 8'h45;
            4'd10:   r = 8'h42;
            4'd11:   r = 8'h50;
            4'd12:   r = 8'h56;
            4'd13:   r = 8'h50;
            4'd14:   r = 8'h38;
            4'd15:   r = 8'h4c;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // one header bit, LSB first
    function automatic t_pstate parse_bit(t_pstate s, logic b);
        t_pstate     r;
        logic [3:0]  fw;
        logic [13:0] acc;
        logic [13:0] v;
        logic [5:0]  rel;
        logic [2:0]  k;
        logic [1:0]  j;
        logic [7:0]  sy;
        logic [1:0]  image;
        logic        bad;
        r     = s;
        rel   = s.step - PS_SYM;
        k     = rel[4:2];
        j     = rel[1:0];
        image = s.flags[1:0];
        bad   = 1'b0;
        sy    = 8'd0;
        v     = 14'd0;
        if (s.fail == FAIL_NONE && s.step != PS_SIG && s.step < PS_DONE) begin
            case (s.step)
                PS_W, PS_H: fw = 4'd14;
                PS_V:       fw = 4'd3;
                PS_TT:      fw = 4'd2;
                PS_TS:      fw = 4'd8;
                default:    fw = (s.step >= PS_SYM && j == 2'd3 && s.flags[2]) ? 4'd8 : 4'd1;
            endcase
            acc = s.accum | (14'(b) << s.bidx);
            if ({1'b0, s.bidx} + 5'd1 >= {1'b0, fw}) begin
                r.accum = 14'd0;
                r.bidx  = 4'd0;
                v       = acc;
                case (s.step)
                    PS_W: begin
                        r.wlo  = v;
                        r.step = PS_H;
                    end
                    PS_H: begin
                        r.hlo  = v;
                        r.step = PS_A;
                    end
                    PS_A: r.step = PS_V;
                    PS_V: begin
                        if (v != 14'd0) r.fail = FAIL_MALFORMED;
                        r.step = PS_TP;
                    end
                    PS_TP: begin
                        if (v == 14'd0) begin
                            r.flags = {1'b0, IMG_DIRECT};
                            r.step  = PS_CC;
                        end else begin
                            r.step = PS_TT;
                        end
                    end
                    PS_CC: begin
                        if (v != 14'd0) r.fail = FAIL_UNSUPPORTED;
                        else r.step = (image == IMG_PALETTE) ? PS_SYM : PS_META;
                    end
                    PS_META: begin
                        if (v != 14'd0) r.fail = FAIL_UNSUPPORTED;
                        else r.step = PS_SYM;
                    end
                    PS_TT: begin
                        if (v != 14'd3) r.fail = FAIL_UNSUPPORTED;
                        else r.step = PS_TS;
                    end
                    PS_TS: begin
                        if (v != 14'd0) begin
                            r.fail = FAIL_UNSUPPORTED;
                        end else begin
                            r.flags = {1'b0, IMG_PALETTE};
                            r.step  = PS_CC;
                        end
                    end
                    PS_MORE: begin
                        if (v != 14'd0) begin
                            r.fail = FAIL_UNSUPPORTED;
                        end else begin
                            r.flags = {1'b0, IMG_INDEX};
                            r.step  = PS_CC;
                        end
                    end
                    default: begin
                        // singleton prefix code fields, four per code
                        case (j)
                            2'd0: bad = (v != 14'd1);
                            2'd1: bad = (v != 14'd0);
                            2'd2: r.flags[2] = v[0];
                            default: begin
                                sy = v[7:0];
                                if (k == 3'd4) begin
                                    bad = (sy >= 8'd40);
                                end else if (image == IMG_INDEX) begin
                                    bad = (k == 3'd0 && sy != 8'd0);
                                end else begin
                                    case (k)
                                        3'd0:    r.pixel[15:8]  = sy;
                                        3'd1:    r.pixel[7:0]   = sy;
                                        3'd2:    r.pixel[23:16] = sy;
                                        default: r.pixel[31:24] = sy;
                                    endcase
                                end
                            end
                        endcase
                        if (bad) r.fail = FAIL_UNSUPPORTED;
                        else if (j == 2'd3 && k == 3'd4)
                            r.step = (image == IMG_PALETTE) ? PS_MORE : PS_DONE;
                        else r.step = s.step + 6'd1;
                    end
                endcase
            end else begin
                r.accum = acc;
                r.bidx  = s.bidx + 4'd1;
            end
        end
        return r;
    endfunction

endpackage

### rtl/vp8l_parse.sv
module vp8l_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  vp8l_pkg::t_in_word i_word,
    input  logic               i_adv,
    output logic               o_snap_valid,
    output vp8l_pkg::t_snap    o_snap
);

    logic [31:0]       r_count, n_count;
    logic              r_tags, n_tags;
    logic [31:0]       r_riff, n_riff;
    logic [31:0]       r_pay, n_pay;
    vp8l_pkg::t_pstate r_ps, n_ps;
    logic              r_snap_valid;
    vp8l_pkg::t_snap   r_snap, n_snap;
    logic [31:0]       rel_off;
    logic [7:0]        b;

    always_comb begin
        b       = i_word.byte_value;
        n_count = (r_count == 32'hffff_ffff) ? r_count : r_count + 32'd1;
        n_tags  = r_tags;
        n_riff  = r_riff;
        n_pay   = r_pay;
        n_ps    = r_ps;
        rel_off = r_count - 32'd20;
        if (r_count < 32'd16) begin
            if (r_count[3:2] == 2'd1) begin
                n_riff[8 * r_count[1:0] +: 8] = r_riff[8 * r_count[1:0] +: 8] | b;
            end else if (b != vp8l_pkg::tag_byte(r_count[3:0])) begin
                n_tags = 1'b0;
            end
        end else if (r_count < 32'd20) begin
            n_pay[8 * r_count[1:0] +: 8] = r_pay[8 * r_count[1:0] +: 8] | b;
        end else if (rel_off < r_pay) begin
            if (r_ps.step == vp8l_pkg::PS_SIG) begin
                if (b != vp8l_pkg::VP8L_SIGNATURE) n_tags = 1'b0;
                n_ps.step = vp8l_pkg::PS_W;
            end else begin
                for (int bi = 0; bi < 8; bi++) begin
                    n_ps = vp8l_pkg::parse_bit(n_ps, b[bi]);
                end
            end
        end
        n_snap.early_bad = (n_count < 32'd25) || !n_tags || (n_riff != n_count - 32'd8)
            || (n_pay > n_count - 32'd20) || (n_pay < 32'd5)
            || (n_ps.fail == vp8l_pkg::FAIL_MALFORMED) || (n_ps.step < vp8l_pkg::PS_TP);
        n_snap.tp_bad    = (n_ps.step == vp8l_pkg::PS_TP);
        n_snap.late_bad  = (n_ps.fail != vp8l_pkg::FAIL_NONE)
            || (n_ps.step != vp8l_pkg::PS_DONE);
        n_snap.wlo       = n_ps.wlo;
        n_snap.hlo       = n_ps.hlo;
        n_snap.pixel     = n_ps.pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_word.last_byte)) begin
            r_count <= '0;
            r_tags  <= 1'b1;
            r_riff  <= '0;
            r_pay   <= '0;
            r_ps    <= '{step: vp8l_pkg::PS_SIG, default: '0};
        end else if (i_accept) begin
            r_count <= n_count;
            r_tags  <= n_tags;
            r_riff  <= n_riff;
            r_pay   <= n_pay;
            r_ps    <= n_ps;
        end
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (i_accept && i_word.last_byte) begin
            r_snap_valid <= 1'b1;
        end else if (i_adv) begin
            r_snap_valid <= 1'b0;
        end
        if (i_accept && i_word.last_byte) r_snap <= n_snap;
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

### rtl/vp8l_status.sv
module vp8l_status (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_snap_valid,
    input  vp8l_pkg::t_snap     i_snap,
    input  logic [14:0]         i_max_dim,
    input  logic [28:0]         i_max_pixels,
    input  logic                i_adv,
    output logic                o_valid,
    output vp8l_pkg::t_out_word o_word
);

    logic                r_valid;
    vp8l_pkg::t_out_word r_word, n_word;
    logic [14:0]         wd, ht;
    logic [29:0]         area;
    logic                budget;

    always_comb begin
        wd     = {1'b0, i_snap.wlo} + 15'd1;
        ht     = {1'b0, i_snap.hlo} + 15'd1;
        area   = wd * ht;
        budget = (wd > i_max_dim) || (ht > i_max_dim) || (area > {1'b0, i_max_pixels});
        if (i_snap.early_bad)                 n_word.status = vp8l_pkg::ST_MALFORMED;
        else if (budget)                      n_word.status = vp8l_pkg::ST_BUDGET;
        else if (wd != 15'd1 || ht != 15'd1)  n_word.status = vp8l_pkg::ST_UNSUPPORTED;
        else if (i_snap.tp_bad)               n_word.status = vp8l_pkg::ST_MALFORMED;
        else if (i_snap.late_bad)             n_word.status = vp8l_pkg::ST_UNSUPPORTED;
        else                                  n_word.status = vp8l_pkg::ST_OK;
        if (n_word.status == vp8l_pkg::ST_OK) begin
            n_word.red   = i_snap.pixel[7:0];
            n_word.green = i_snap.pixel[15:8];
            n_word.blue  = i_snap.pixel[23:16];
            n_word.alpha = i_snap.pixel[31:24];
        end else begin
            n_word.red   = 8'd0;
            n_word.green = 8'd0;
            n_word.blue  = 8'd0;
            n_word.alpha = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_snap_valid;
        end
        if (i_adv) r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### rtl/vp8l_single_pixel_decoder.sv
// Streaming checker/decoder for a one-pixel WebP lossless file. One byte
// word is taken per cycle, back to back, while the input is not stalled;
// every byte goes through the container checks and an eight-bit unrolled
// header parse in the cycle it is accepted. The word marked last_byte
// produces one result word through an end-of-file summary register, then
// the status stage register, which does the width*height budget multiply.
// The input stalls only while a summary is held and the output word is
// stalled. Status 0 carries the RGBA pixel; any other status carries zero
// channels. After each last byte the parser starts a new file.
// Configuration writes (index 0 max_dimension, 1 max_pixels) are taken in
// any cycle out of reset with i_cfg_we high.
`include "vp8l_single_pixel_decoder_assert.svh"
module vp8l_single_pixel_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  vp8l_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output vp8l_pkg::t_out_word o_out_data,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [28:0]         i_cfg_data
);

    logic [14:0]     r_max_dim;
    logic [28:0]     r_max_pixels;
    logic            snap_valid;
    vp8l_pkg::t_snap snap;
    logic            adv;
    logic            accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dim    <= vp8l_pkg::MAX_DIM_RESET;
            r_max_pixels <= vp8l_pkg::MAX_PIXELS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vp8l_pkg::CFG_MAX_DIM:    r_max_dim    <= i_cfg_data[14:0];
                vp8l_pkg::CFG_MAX_PIXELS: r_max_pixels <= i_cfg_data;
                default:                  ;
            endcase
        end
    end

    // output slot frees when empty or taken
    assign adv        = !o_out_valid || !i_out_stall;
    assign o_in_stall = snap_valid && !adv;
    assign accept     = i_in_valid && !o_in_stall;

    vp8l_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_word       (i_in_data),
        .i_adv        (adv),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    vp8l_status u_status (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .i_max_dim    (r_max_dim),
        .i_max_pixels (r_max_pixels),
        .i_adv        (adv),
        .o_valid      (o_out_valid),
        .o_word       (o_out_data)
    );

    // error results never carry pixel data
    `VP8L_ASSERT_NOW(a_err_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.status != vp8l_pkg::ST_OK,
        o_out_data.red == 8'd0 && o_out_data.alpha == 8'd0)
    // input backpressure only when a summary is held up
    `VP8L_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        snap_valid && o_out_valid && i_out_stall)
    // an accepted last byte lands in the summary register
    `VP8L_ASSERT_NEXT(a_last_snap, i_clk, i_rst_n,
        accept && i_in_data.last_byte, snap_valid)
    // a held summary moves into a free output slot
    `VP8L_ASSERT_NEXT(a_snap_moves, i_clk, i_rst_n, snap_valid && adv, o_out_valid)

endmodule

### verif/vp8l_decoder_checker.sv
module vp8l_decoder_checker
    import vp8l_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_data,
    input  logic      i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [28:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_pending
);
    // configuration copy
    logic [14:0] max_dim;
    logic [28:0] max_pix;

    // per-file parser state
    logic [31:0] nbytes;
    logic        tags_good;
    logic [31:0] riff_len;
    logic [31:0] chunk_len;
    logic [5:0]  step;
    logic [13:0] accum;
    logic [3:0]  bidx;
    logic [13:0] wlo, hlo;
    logic [2:0]  flags;
    logic [1:0]  fail;
    logic [31:0] pixel;

    t_out_word pixel_q[$];

    assign o_pending = pixel_q.size();

    function automatic logic [7:0] hdr_tag(int idx);
        case (idx)
            0: return 8'h52;  1: return 8'h49;  2: return 8'h46;  3: return 8'h46;
            8: return 8'h57;  9: return 8'h45; 10: return 8'h42; 11: return 8'h50;
            12: return 8'h56; 13: return 8'h50; 14: return 8'h38; default: return 8'h4c;
        endcase
    endfunction

    task automatic clear_file();
        nbytes = 0; tags_good = 1; riff_len = 0; chunk_len = 0;
        step = PS_SIG; accum = 0; bidx = 0; wlo = 0; hlo = 0;
        flags = 0; fail = FAIL_NONE; pixel = 0;
    endtask

    task automatic field_end(logic [13:0] v);
        logic [1:0] image;
        int rel, k, j, sh;
        image = flags[1:0];
        case (step)
            PS_W: begin wlo = v; step = PS_H; end
            PS_H: begin hlo = v; step = PS_A; end
            PS_A: step = PS_V;
            PS_V: begin
                if (v != 0) fail = FAIL_MALFORMED;
                step = PS_TP;
            end
            PS_TP: begin
                if (v == 0) begin flags = {1'b0, IMG_DIRECT}; step = PS_CC; end
                else step = PS_TT;
            end
            PS_CC: begin
                if (v != 0) fail = FAIL_UNSUPPORTED;
                else step = (image == IMG_PALETTE) ? PS_SYM : PS_META;
            end
            PS_META: begin
                if (v != 0) fail = FAIL_UNSUPPORTED;
                else step = PS_SYM;
            end
            PS_TT: begin
                if (v != 3) fail = FAIL_UNSUPPORTED;
                else step = PS_TS;
            end
            PS_TS: begin
                if (v != 0) fail = FAIL_UNSUPPORTED;
                else begin flags = {1'b0, IMG_PALETTE}; step = PS_CC; end
            end
            PS_MORE: begin
                if (v != 0) fail = FAIL_UNSUPPORTED;
                else begin flags = {1'b0, IMG_INDEX}; step = PS_CC; end
            end
            default: begin
                rel = step - PS_SYM;
                k = rel >> 2;
                j = rel & 3;
                if (j == 0 && v != 1) begin fail = FAIL_UNSUPPORTED; return; end
                if (j == 1 && v != 0) begin fail = FAIL_UNSUPPORTED; return; end
                if (j == 2) flags[2] = v[0];
                if (j == 3) begin
                    if (k == 4) begin
                        if (v[7:0] >= 40) begin fail = FAIL_UNSUPPORTED; return; end
                        step = (image == IMG_PALETTE) ? PS_MORE : PS_DONE;
                        return;
                    end else if (image == IMG_INDEX) begin
                        if (k == 0 && v[7:0] != 0) begin
                            fail = FAIL_UNSUPPORTED;
                            return;
                        end
                    end else begin
                        // green, red, blue, alpha in code order
                        sh = (k == 0) ? 8 : (k == 1) ? 0 : (k == 2) ? 16 : 24;
                        pixel[sh +: 8] = v[7:0];
                    end
                end
                step = step + 1;
            end
        endcase
    endtask

    task automatic header_bits(logic [7:0] b);
        int fw, rel;
        for (int i = 0; i < 8; i++) begin
            if (fail != FAIL_NONE || step == PS_SIG || step >= PS_DONE) return;
            rel = step - PS_SYM;
            case (step)
                PS_W, PS_H: fw = 14;
                PS_V:       fw = 3;
                PS_TT:      fw = 2;
                PS_TS:      fw = 8;
                default:    fw = (step >= PS_SYM && (rel & 3) == 3 && flags[2]) ? 8 : 1;
            endcase
            accum = accum | (14'(b[i]) << bidx);
            if (bidx + 1 >= fw) begin
                logic [13:0] v;
                v = accum;
                accum = 0;
                bidx = 0;
                field_end(v);
            end else begin
                bidx = bidx + 1;
            end
        end
    endtask

    function automatic logic [1:0] file_status();
        logic [31:0] w, h;
        if (nbytes < 25 || !tags_good) return ST_MALFORMED;
        if (riff_len != nbytes - 8) return ST_MALFORMED;
        if (chunk_len > nbytes - 20 || chunk_len < 5) return ST_MALFORMED;
        if (fail == FAIL_MALFORMED || step < PS_TP) return ST_MALFORMED;
        w = wlo + 1;
        h = hlo + 1;
        if (w > max_dim || h > max_dim || w > max_pix / h) return ST_BUDGET;
        if (w != 1 || h != 1) return ST_UNSUPPORTED;
        if (step == PS_TP) return ST_MALFORMED;
        if (fail != FAIL_NONE || step != PS_DONE) return ST_UNSUPPORTED;
        return ST_OK;
    endfunction

    task automatic take_byte(t_in_word wd);
        logic [31:0] i;
        t_out_word res;
        i = nbytes;
        if (i < 4 || (i >= 8 && i < 16)) begin
            if (wd.byte_value != hdr_tag(i)) tags_good = 0;
        end else if (i < 8) begin
            riff_len[8*(i-4) +: 8] = wd.byte_value;
        end else if (i < 20) begin
            chunk_len[8*(i-16) +: 8] = wd.byte_value;
        end else if (nbytes - 20 < chunk_len) begin
            if (step == PS_SIG) begin
                if (wd.byte_value != VP8L_SIGNATURE) tags_good = 0;
                step = PS_W;
            end else begin
                header_bits(wd.byte_value);
            end
        end
        if (nbytes != 32'hffff_ffff) nbytes++;
        if (wd.last_byte) begin
            res = '0;
            res.status = file_status();
            if (res.status == ST_OK) begin
                res.red = pixel[7:0];
                res.green = pixel[15:8];
                res.blue = pixel[23:16];
                res.alpha = pixel[31:24];
            end
            pixel_q.push_back(res);
            clear_file();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_dim <= MAX_DIM_RESET;
            max_pix <= MAX_PIXELS_RESET;
            clear_file();
            pixel_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_DIM) max_dim <= i_cfg_data[14:0];
                else max_pix <= i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) take_byte(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result word %h", i_out_data);
                end else begin
                    t_out_word exp_w;
                    exp_w = pixel_q.pop_front();
                    if (exp_w != i_out_data) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: st %0d/%0d r %h/%h g %h/%h b %h/%h a %h/%h",
                                exp_w.status, i_out_data.status, exp_w.red,
                                i_out_data.red, exp_w.green, i_out_data.green,
                                exp_w.blue, i_out_data.blue, exp_w.alpha,
                                i_out_data.alpha);
                    end
                end
            end
        end
    end
endmodule

### verif/tb_vp8l_single_pixel_decoder.sv
module tb_vp8l_single_pixel_decoder;
    import vp8l_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    t_in_word    in_data = '0;
    logic        out_valid;
    logic        out_stall = 0;
    t_out_word   out_data;
    logic        cfg_we = 0;
    logic [0:0]  cfg_index = CFG_MAX_DIM;
    logic [28:0] cfg_data = '0;
    int          fail_count;
    int          pending;

    // idle rates in percent; hold_cycles > 0 forces a long output stall
    int  send_idle = 0;
    int  recv_idle = 0;
    int  hold_cycles = 0;
    longint cycles = 0;
    byte unsigned file_buf[$];

    always #1 clk = ~clk;

    vp8l_single_pixel_decoder dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    vp8l_decoder_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall, one assignment per edge
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // watchdog ends the run with a failure once the cycle counter passes its limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("** vp8l_single_pixel_decoder: FAILED **");
            $finish;
        end
    end

    // send one byte word, holding it until accepted; valid drops when the
    // sender idles or the stream is drained
    task automatic send_word(byte unsigned b, bit last);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{byte_value: b, last_byte: last};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_file();
        foreach (file_buf[i]) send_word(file_buf[i], i == file_buf.size() - 1);
        file_buf.delete();
    endtask

    // LSB-first bit packer for the VP8L header
    int unsigned bit_acc;
    int          bit_cnt;
    task automatic put_bits(int unsigned v, int n);
        for (int i = 0; i < n; i++) begin
            bit_acc |= ((v >> i) & 1) << bit_cnt;
            bit_cnt++;
            if (bit_cnt == 8) begin
                file_buf.push_back(bit_acc[7:0]);
                bit_acc = 0;
                bit_cnt = 0;
            end
        end
    endtask

    // singleton prefix code: simple=1, one symbol, 1- or 8-bit symbol
    task automatic put_code(byte unsigned sym, bit wide);
        put_bits(1, 1);
        put_bits(0, 1);
        put_bits(wide, 1);
        put_bits(sym, wide ? 8 : 1);
    endtask

    // build a file; mode 0 direct pixel, 1 palette, corrupt picks a fault
    task automatic make_file(int mode, int wlo, int hlo, int corrupt);
        byte unsigned body[$];
        int unsigned psize, rsize;
        int k;
        bit_acc = 0;
        bit_cnt = 0;
        file_buf.delete();
        file_buf.push_back(VP8L_SIGNATURE);
        put_bits(wlo, 14);
        put_bits(hlo, 14);
        put_bits($urandom_range(1), 1);
        put_bits(corrupt == 3 ? $urandom_range(7, 1) : 0, 3);
        if (mode == 1) begin
            put_bits(1, 1);
            put_bits(corrupt == 4 ? $urandom_range(2) : 3, 2);
            put_bits(0, 8);
            put_bits(0, 1);
            for (k = 0; k < 5; k++)
                put_code(k == 4 ? $urandom_range(39) : $urandom_range(255), 1);
            // no further transform, no color cache, no meta codes
            put_bits(0, 1);
            put_bits(0, 1);
            put_bits(0, 1);
            for (k = 0; k < 5; k++) put_code(0, $urandom_range(1));
        end else begin
            put_bits(0, 1);
            put_bits(0, 1);
            put_bits(0, 1);
            for (k = 0; k < 5; k++) begin
                if (corrupt == 5 && k == 4) put_code(40 + $urandom_range(215), 1);
                else put_code(k == 4 ? $urandom_range(39) : $urandom_range(255), 1);
            end
        end
        if (bit_cnt != 0) put_bits(0, 8 - bit_cnt);
        if (corrupt == 6) void'(file_buf.pop_back());
        psize = file_buf.size();
        rsize = psize + 12;
        body = file_buf;
        file_buf = '{8'h52, 8'h49, 8'h46, 8'h46};
        if (corrupt == 1) file_buf[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        if (corrupt == 2) rsize += $urandom_range(3, 1);
        for (k = 0; k < 4; k++) file_buf.push_back(8'(rsize >> (8 * k)));
        file_buf.push_back(8'h57); file_buf.push_back(8'h45);
        file_buf.push_back(8'h42); file_buf.push_back(8'h50);
        file_buf.push_back(8'h56); file_buf.push_back(8'h50);
        file_buf.push_back(8'h38); file_buf.push_back(8'h4c);
        for (k = 0; k < 4; k++) file_buf.push_back(8'(psize >> (8 * k)));
        file_buf = {file_buf, body};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [28:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    int sent;
    int n;

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: good direct, good palette, each fault, large dims, a 2x1 image
        make_file(0, 0, 0, 0); send_file();
        make_file(1, 0, 0, 0); send_file();
        for (int c = 1; c <= 6; c++) begin
            make_file(c == 4 ? 1 : 0, 0, 0, c);
            send_file();
        end
        make_file(0, 16383, 16383, 0); send_file();
        make_file(0, 1, 0, 0); send_file();
        // too short, then a lone last byte
        send_word(8'h52, 0); send_word(8'hff, 1);
        send_word(8'h00, 1);
        wait_drained();

        // budget extremes
        write_cfg(CFG_MAX_DIM, 29'd1);
        write_cfg(CFG_MAX_PIXELS, 29'd1);
        make_file(0, 0, 0, 0); send_file();
        make_file(0, 1, 0, 0); send_file();
        wait_drained();
        write_cfg(CFG_MAX_DIM, 29'h7fff);
        write_cfg(CFG_MAX_PIXELS, 29'h1fff_ffff);
        make_file(0, 16383, 16383, 0); send_file();
        wait_drained();

        // pressure: long output hold while bytes keep coming
        hold_cycles <= 200;
        make_file(0, 0, 0, 0); send_file();
        make_file(1, 0, 0, 0); send_file();
        make_file(0, 0, 0, 0); send_file();
        wait_drained();

        sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 12 : (ph == 1) ? 53 : 0;
            recv_idle = (ph == 0) ? 53 : (ph == 1) ? 12 : 0;
            write_cfg(CFG_MAX_DIM, 29'($urandom_range(16384, 1)));
            write_cfg(CFG_MAX_PIXELS, 29'($urandom_range(64, 1)));
            for (n = 0; n < 285 / 3; n = n + 0) begin
                int r;
                r = $urandom_range(99);
                if (r < 70) begin
                    make_file($urandom_range(1), $urandom_range(3) == 0 ?
                        $urandom_range(16383) : 0, $urandom_range(3) == 0 ?
                        $urandom_range(16383) : 0, $urandom_range(3) == 0 ?
                        $urandom_range(6, 1) : 0);
                end else begin
                    // noise file of random bytes
                    int len;
                    len = $urandom_range(40, 1);
                    repeat (len) file_buf.push_back($urandom_range(255));
                end
                sent += file_buf.size();
                n = (sent - ph * 285) / 3;
                if (sent > (ph + 1) * 285) n = 285;
                send_file();
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("** vp8l_single_pixel_decoder: PASSED **");
        end else begin
            $display("** vp8l_single_pixel_decoder: FAILED **");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/vp8l_pkg.sv
rtl/vp8l_parse.sv
rtl/vp8l_status.sv
rtl/vp8l_single_pixel_decoder.sv
verif/vp8l_decoder_checker.sv
verif/tb_vp8l_single_pixel_decoder.sv
